// ===== rtl/gtd_pkg.sv =====
// ----------------------------------------------------------------------------
// gtd_pkg
// Shared types and constants of the graphics tag packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtd_pkg;

  // Input item kinds (slave tuser)
  localparam logic [1:0] KindFifo  = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;

  // Result kinds (master tuser, low bits)
  localparam logic [1:0] ResForward = 2'd0;
  localparam logic [1:0] ResRead    = 2'd1;
  localparam logic [1:0] ResAbort   = 2'd2;

  // Register indexes
  localparam logic [3:0] RegControl = 4'd0;
  localparam logic [3:0] RegMode    = 4'd1;
  localparam logic [3:0] RegStatus  = 4'd2;

  // Tag layout
  localparam int LoopW    = 15;
  localparam int FmtLsb   = 58;
  localparam int NregsLsb = 60;
  localparam int CountW   = 20;
  localparam int FillW    = 5;
  localparam int FillLsb  = 24;

  // Tag formats
  localparam logic [1:0] FmtPacked  = 2'd0;
  localparam logic [1:0] FmtReglist = 2'd1;

  // Stream widths
  localparam int SDataW = 168;
  localparam int SUserW = 2;
  localparam int MDataW = 136;
  localparam int MUserW = 3;

  localparam int QueueDepth = 2;

  // Work for the back part, as classified by the front part
  typedef enum logic [1:0] {
    OpForward    = 2'd0,
    OpReadStatus = 2'd1,
    OpReadZero   = 2'd2,
    OpAbort      = 2'd3
  } gtd_op_e;

  typedef struct packed {
    gtd_op_e     op;
    logic [1:0]  path;
    logic [63:0] qw_high;
    logic [63:0] qw_low;
  } gtd_entry_t;

endpackage

`default_nettype wire

// ===== rtl/gtd_front.sv =====
// ----------------------------------------------------------------------------
// gtd_front
// Accepts input transactions and classifies them into work for the back part.
// Transactions that cause no result are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module gtd_front (
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [gtd_pkg::SDataW-1:0]  s_axis_tdata,
  input  wire logic [gtd_pkg::SUserW-1:0]  s_axis_tuser,
  input  wire logic                        q_full_i,
  output      logic                        q_push_o,
  output      gtd_pkg::gtd_entry_t         q_entry_o
);

  logic [1:0]  path;
  logic [63:0] qw_low;
  logic [63:0] qw_high;
  logic [3:0]  reg_index;
  logic [31:0] write_value;
  logic        has_result;

  assign path        = s_axis_tdata[1:0];
  assign qw_low      = s_axis_tdata[65:2];
  assign qw_high     = s_axis_tdata[129:66];
  assign reg_index   = s_axis_tdata[133:130];
  assign write_value = s_axis_tdata[165:134];

  assign s_axis_tready = !q_full_i;

  always_comb begin
    has_result        = 1'b0;
    q_entry_o.op      = gtd_pkg::OpForward;
    q_entry_o.path    = path;
    q_entry_o.qw_low  = qw_low;
    q_entry_o.qw_high = qw_high;
    unique case (s_axis_tuser)
      gtd_pkg::KindFifo: begin
        has_result   = 1'b1;
        q_entry_o.op = gtd_pkg::OpForward;
      end
      gtd_pkg::KindRead: begin
        has_result   = 1'b1;
        q_entry_o.op = (reg_index == gtd_pkg::RegStatus) ? gtd_pkg::OpReadStatus
                                                         : gtd_pkg::OpReadZero;
      end
      gtd_pkg::KindWrite: begin
        // only a control write with the reset bit set does anything
        has_result   = (reg_index == gtd_pkg::RegControl) && write_value[0];
        q_entry_o.op = gtd_pkg::OpAbort;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  assign q_push_o = s_axis_tvalid && s_axis_tready && has_result;

endmodule

`default_nettype wire

// ===== rtl/gtd_queue.sv =====
// ----------------------------------------------------------------------------
// gtd_queue
// Short first-word-fall-through queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module gtd_queue #(
  parameter int DEPTH = gtd_pkg::QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire gtd_pkg::gtd_entry_t entry_i,
  output      logic                full_o,
  output      logic                empty_o,
  input  wire logic                pop_i,
  output      gtd_pkg::gtd_entry_t entry_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  gtd_pkg::gtd_entry_t mem_q [DEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/gtd_back.sv =====
// ----------------------------------------------------------------------------
// gtd_back
// Carries out queued work: tag parsing, packet tracking, status register,
// abort. Results leave through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire gtd_pkg::gtd_entry_t        q_entry_i,
  output      logic                       q_pop_o,
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output      logic [gtd_pkg::MDataW-1:0] m_axis_tdata,
  output      logic [gtd_pkg::MUserW-1:0] m_axis_tuser,
  output      logic                       m_axis_tlast
);

  localparam int CountW = gtd_pkg::CountW;
  localparam int FillW  = gtd_pkg::FillW;

  logic                   in_packet_q, in_packet_d;
  logic [CountW-1:0]      data_left_q, data_left_d;
  logic [FillW-1:0]       fill_q, fill_d;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_kind_q, out_kind_d;
  logic [63:0]            out_low_q, out_low_d;
  logic [63:0]            out_high_q, out_high_d;
  logic [1:0]             out_path_q, out_path_d;
  logic                   out_tag_q, out_tag_d;
  logic                   out_eop_q, out_eop_d;

  logic [gtd_pkg::LoopW-1:0] loops;
  logic [1:0]             fmt;
  logic [4:0]             regs;
  logic [CountW-1:0]      prod;
  logic [CountW-1:0]      half;
  logic [CountW-1:0]      tag_count;
  logic [CountW-1:0]      left_dec;

  // tag decode
  assign loops = q_entry_i.qw_low[gtd_pkg::LoopW-1:0];
  assign fmt   = q_entry_i.qw_low[gtd_pkg::FmtLsb+1:gtd_pkg::FmtLsb];
  assign regs  = (q_entry_i.qw_low[gtd_pkg::NregsLsb+3:gtd_pkg::NregsLsb] == 4'd0)
               ? 5'd16 : {1'b0, q_entry_i.qw_low[gtd_pkg::NregsLsb+3:gtd_pkg::NregsLsb]};
  assign prod  = CountW'({5'd0, loops} * {15'd0, regs});
  assign half  = CountW'(({1'b0, prod} + 21'd1) >> 1);

  always_comb begin
    case (fmt)
      gtd_pkg::FmtPacked:  tag_count = prod;
      gtd_pkg::FmtReglist: tag_count = half;
      default:             tag_count = {5'd0, loops};
    endcase
  end

  assign left_dec = data_left_q - CountW'(1);

  assign q_pop_o = !q_empty_i && (!out_valid_q || m_axis_tready);

  always_comb begin
    in_packet_d = in_packet_q;
    data_left_d = data_left_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;
    out_path_d  = out_path_q;
    out_tag_d   = out_tag_q;
    out_eop_d   = out_eop_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
      out_kind_d  = gtd_pkg::ResForward;
      out_low_d   = '0;
      out_high_d  = '0;
      out_path_d  = '0;
      out_tag_d   = 1'b0;
      out_eop_d   = 1'b0;
      unique case (q_entry_i.op)
        gtd_pkg::OpForward: begin
          fill_d     = '1;
          out_low_d  = q_entry_i.qw_low;
          out_high_d = q_entry_i.qw_high;
          out_path_d = q_entry_i.path;
          if (!in_packet_q || (data_left_q == '0)) begin
            // take as a tag; an empty tag leaves the packet closed
            data_left_d = tag_count;
            in_packet_d = (tag_count != '0);
            out_tag_d   = 1'b1;
          end else begin
            data_left_d = left_dec;
            in_packet_d = (left_dec != '0);
            out_eop_d   = (left_dec == '0);
          end
        end
        gtd_pkg::OpReadStatus: begin
          out_kind_d = gtd_pkg::ResRead;
          out_low_d  = 64'({fill_q, gtd_pkg::FillLsb'(0)});
          fill_d     = '0;
        end
        gtd_pkg::OpReadZero: begin
          out_kind_d = gtd_pkg::ResRead;
        end
        gtd_pkg::OpAbort: begin
          out_kind_d  = gtd_pkg::ResAbort;
          in_packet_d = 1'b0;
          data_left_d = '0;
          fill_d      = '0;
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      data_left_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_packet_q <= in_packet_d;
      data_left_q <= data_left_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_low_q  <= out_low_d;
    out_high_q <= out_high_d;
    out_path_q <= out_path_d;
    out_tag_q  <= out_tag_d;
    out_eop_q  <= out_eop_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_path_q, out_high_q, out_low_q};
  assign m_axis_tuser  = {out_tag_q, out_kind_q};
  assign m_axis_tlast  = out_eop_q;

  a_packet_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_packet_q == (data_left_q != '0))
    else $error("packet flag disagrees with remaining count");

  a_non_forward_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != gtd_pkg::ResForward)) |->
      (out_high_q == '0) && (out_path_q == '0) && !out_tag_q && !out_eop_q)
    else $error("read or abort result carries forward fields");

  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && (q_entry_i.op == gtd_pkg::OpAbort)) |=>
      !in_packet_q && (fill_q == '0) && (out_low_q == '0))
    else $error("abort did not clear state");

  a_tag_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_tag_q && out_eop_q))
    else $error("tag marked as end of packet");

endmodule

`default_nettype wire

// ===== rtl/graphics_tag_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// graphics_tag_packet_deframer_unit
// Result path: after its input transaction is accepted, a result passes the queue
//   register and then the back part's output register to the master side.
// Throughput: one transaction per cycle while the output does not stall; tag
//   decode in the back part is combinational; the queue absorbs stalls of up to DEPTH items.
// Reset: rst_ni clears packet state, status fill field, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module graphics_tag_packet_deframer_unit #(
  parameter int QUEUE_DEPTH = gtd_pkg::QueueDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  // path[1:0], qw_low[65:2], qw_high[129:66], reg_index[133:130],
  // write_value[165:134], zero pad[167:166]
  input  wire logic [gtd_pkg::SDataW-1:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [gtd_pkg::SUserW-1:0] s_axis_tuser,
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // word_low[63:0], word_high[127:64], path_out[129:128], zero pad[135:130]
  output      logic [gtd_pkg::MDataW-1:0] m_axis_tdata,
  // result_kind[1:0], is_tag[2]
  output      logic [gtd_pkg::MUserW-1:0] m_axis_tuser,
  // end_of_packet
  output      logic                       m_axis_tlast
);

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  gtd_pkg::gtd_entry_t q_wr_entry;
  gtd_pkg::gtd_entry_t q_rd_entry;

  gtd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_wr_entry)
  );

  gtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry)
  );

  gtd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rd_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for graphics_tag_packet_deframer_unit. A behavioral
// deframer tracks packet state and the status fill field and predicts every
// result. A checker compares each master-side transaction with the oldest
// prediction. Directed register, tag-format and abort cases come first, then
// randomized packet traffic. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindIgnored = 2'd3;
  localparam logic [1:0] FmtImageAlt = 2'd3;
  localparam int RandomItems = 1800;
  localparam int CalmFirst   = 700;
  localparam int CalmLast    = 1000;
  localparam int MaxReported = 10;
  localparam int LongPacket  = 200;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  path;
    logic [63:0] qw_low;
    logic [63:0] qw_high;
    logic [3:0]  reg_index;
    logic [31:0] write_value;
  } bus_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [1:0]  path;
    logic        is_tag;
    logic        eop;
  } deframed_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [gtd_pkg::SDataW-1:0]   s_axis_tdata = '0;
  logic [gtd_pkg::SUserW-1:0]   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [gtd_pkg::MDataW-1:0]   m_axis_tdata;
  logic [gtd_pkg::MUserW-1:0]   m_axis_tuser;
  logic                         m_axis_tlast;

  // Behavioral deframer state
  bit                           pkt_open = 1'b0;
  logic [gtd_pkg::CountW-1:0]   qw_remaining = '0;
  logic [gtd_pkg::FillW-1:0]    fill_level = '0;
  deframed_t                    due_results[$];

  deframed_t                    seen_result;
  bit                           seen_valid = 1'b0;
  bit                           no_idle = 1'b0;
  int                           fail_count = 0;

  always #1 clk_i = ~clk_i;

  graphics_tag_packet_deframer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] make_tag(logic [gtd_pkg::LoopW-1:0] loops,
                                           logic [1:0] fmt, logic [3:0] regs);
    logic [63:0] w;
    w = rand64();
    w[gtd_pkg::LoopW-1:0] = loops;
    w[gtd_pkg::FmtLsb +: 2] = fmt;
    w[gtd_pkg::NregsLsb +: 4] = regs;
    return w;
  endfunction

  function automatic bus_item_t quadword(logic [1:0] path, logic [63:0] lo, logic [63:0] hi);
    bus_item_t it;
    it.kind = gtd_pkg::KindFifo;
    it.path = path;
    it.qw_low = lo;
    it.qw_high = hi;
    it.reg_index = 4'($urandom_range(0, 15));
    it.write_value = $urandom;
    return it;
  endfunction

  function automatic bus_item_t reg_access(logic [1:0] kind, logic [3:0] idx, logic [31:0] wv);
    bus_item_t it;
    it.kind = kind;
    it.path = 2'($urandom_range(0, 3));
    it.qw_low = rand64();
    it.qw_high = rand64();
    it.reg_index = idx;
    it.write_value = wv;
    return it;
  endfunction

  function automatic string fmt_result(deframed_t r);
    return $sformatf("kind %0d low %h high %h path %0d tag %0b last %0b",
                     r.kind, r.word_low, r.word_high, r.path, r.is_tag, r.eop);
  endfunction

  // Number of data quadwords announced by a tag
  function automatic logic [gtd_pkg::CountW-1:0] tag_payload_count(logic [63:0] lo);
    int unsigned loops;
    int unsigned regs;
    int unsigned n;
    loops = 32'(lo[gtd_pkg::LoopW-1:0]);
    regs = 32'(lo[gtd_pkg::NregsLsb +: 4]);
    if (regs == 0) regs = 16;
    n = loops * regs;
    case (lo[gtd_pkg::FmtLsb +: 2])
      gtd_pkg::FmtPacked:  return gtd_pkg::CountW'(n);
      gtd_pkg::FmtReglist: return gtd_pkg::CountW'((n + 1) / 2);
      default:             return gtd_pkg::CountW'(loops);
    endcase
  endfunction

  task automatic predict_deframed(input bus_item_t it);
    deframed_t r;
    logic [gtd_pkg::CountW-1:0] n;
    r = '0;
    case (it.kind)
      gtd_pkg::KindFifo: begin
        fill_level = '1;
        r.kind = gtd_pkg::ResForward;
        r.word_low = it.qw_low;
        r.word_high = it.qw_high;
        r.path = it.path;
        if (!pkt_open || qw_remaining == 0) begin
          n = tag_payload_count(it.qw_low);
          qw_remaining = n;
          pkt_open = (n != 0);
          r.is_tag = 1'b1;
        end else begin
          qw_remaining = qw_remaining - 1'b1;
          if (qw_remaining == 0) begin
            pkt_open = 1'b0;
            r.eop = 1'b1;
          end
        end
        due_results.push_back(r);
      end
      gtd_pkg::KindRead: begin
        r.kind = gtd_pkg::ResRead;
        if (it.reg_index == gtd_pkg::RegStatus) begin
          r.word_low = 64'(fill_level) << gtd_pkg::FillLsb;
          fill_level = '0;
        end
        due_results.push_back(r);
      end
      gtd_pkg::KindWrite: begin
        if (it.reg_index == gtd_pkg::RegControl && it.write_value[0]) begin
          pkt_open = 1'b0;
          qw_remaining = '0;
          fill_level = '0;
          r.kind = gtd_pkg::ResAbort;
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) $display("ERROR: %s", msg);
  endtask

  // Present one item and hold it until the transaction completes
  task automatic send_item(input bus_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, it.write_value, it.reg_index, it.qw_high, it.qw_low, it.path};
    s_axis_tuser <= it.kind;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    predict_deframed(it);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 29);
  end

  // Sample at the falling edge, compare at the next falling edge so that predictions
  // pushed at the accepting edge are already queued.
  always @(negedge clk_i) begin
    deframed_t want;
    if (seen_valid) begin
      if (due_results.size() == 0) begin
        note_failure({"unexpected result: ", fmt_result(seen_result)});
      end else begin
        want = due_results.pop_front();
        if (seen_result !== want)
          note_failure({"mismatch: expected ", fmt_result(want), " got ",
                        fmt_result(seen_result)});
      end
      seen_valid = 1'b0;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result.kind = m_axis_tuser[1:0];
      seen_result.is_tag = m_axis_tuser[2];
      seen_result.word_low = m_axis_tdata[63:0];
      seen_result.word_high = m_axis_tdata[127:64];
      seen_result.path = m_axis_tdata[129:128];
      seen_result.eop = m_axis_tlast;
      seen_valid = 1'b1;
    end
  end

  task automatic test_register_access();
    send_item(reg_access(gtd_pkg::KindRead, gtd_pkg::RegStatus, $urandom));
    send_item(reg_access(gtd_pkg::KindRead, gtd_pkg::RegControl, '1));
    send_item(reg_access(gtd_pkg::KindWrite, gtd_pkg::RegMode, '1));
    // control write without the reset bit does nothing
    send_item(reg_access(gtd_pkg::KindWrite, gtd_pkg::RegControl, 32'hffff_fffe));
    send_item(reg_access(KindIgnored, gtd_pkg::RegControl, '1));
  endtask

  task automatic test_tag_formats();
    // empty tag on path three, then status reads set and cleared
    send_item(quadword(2'd3, make_tag(15'd0, gtd_pkg::FmtPacked, 4'd5), '1));
    send_item(reg_access(gtd_pkg::KindRead, gtd_pkg::RegStatus, '0));
    send_item(reg_access(gtd_pkg::KindRead, gtd_pkg::RegStatus, '0));
    send_item(quadword(2'd0, make_tag(15'd1, gtd_pkg::FmtPacked, 4'd2), '0));
    repeat (2) send_item(quadword(2'd1, rand64(), rand64()));
    send_item(quadword(2'd2, make_tag(15'd3, gtd_pkg::FmtReglist, 4'd1), rand64()));
    repeat (2) send_item(quadword(2'd2, rand64(), rand64()));
    // register count zero stands for sixteen; image uses the loop count only
    send_item(quadword(2'd1, make_tag(15'd1, FmtImageAlt, 4'd0), rand64()));
    send_item(quadword(2'd3, rand64(), rand64()));
  endtask

  task automatic test_abort_open_packet();
    send_item(quadword(2'd1, '1, '0));
    send_item(quadword(2'd2, '0, '1));
    send_item(reg_access(gtd_pkg::KindWrite, gtd_pkg::RegControl, '1));
    send_item(reg_access(gtd_pkg::KindRead, gtd_pkg::RegStatus, '0));
    send_item(quadword(2'd0, make_tag('1, gtd_pkg::FmtPacked, 4'd0), rand64()));
    send_item(reg_access(gtd_pkg::KindWrite, gtd_pkg::RegControl, 32'd1));
  endtask

  function automatic bus_item_t register_noise();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    return reg_access(gtd_pkg::KindRead, gtd_pkg::RegStatus, $urandom);
      2, 3:    return reg_access(gtd_pkg::KindRead, 4'($urandom_range(0, 15)), $urandom);
      4, 5:    return reg_access(gtd_pkg::KindWrite, gtd_pkg::RegControl, $urandom);
      6, 7:    return reg_access(gtd_pkg::KindWrite, 4'($urandom_range(0, 15)), $urandom);
      8:       return reg_access(gtd_pkg::KindWrite, gtd_pkg::RegMode, $urandom);
      default: return reg_access(KindIgnored, 4'($urandom_range(0, 15)), $urandom);
    endcase
  endfunction

  function automatic logic [63:0] random_tag_word();
    logic [gtd_pkg::LoopW-1:0] loops;
    loops = ($urandom_range(0, 99) < 90) ? gtd_pkg::LoopW'($urandom_range(0, 6))
                                         : gtd_pkg::LoopW'($urandom_range(7, 40));
    return make_tag(loops, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endfunction

  task automatic test_random_traffic();
    int counted;
    int roll;
    bus_item_t it;
    counted = 0;
    while (counted < RandomItems) begin
      no_idle = (counted >= CalmFirst && counted < CalmLast);
      roll = $urandom_range(0, 99);
      if (qw_remaining > LongPacket && roll < 20)
        // cut oversized packets short
        it = reg_access(gtd_pkg::KindWrite, gtd_pkg::RegControl, $urandom | 32'd1);
      else if (!pkt_open && roll < 78)
        it = quadword(2'($urandom_range(0, 3)), random_tag_word(), rand64());
      else if (!pkt_open && roll < 82)
        it = quadword(2'($urandom_range(0, 3)), rand64(), rand64());
      else if (pkt_open && roll < 90)
        it = quadword(2'($urandom_range(0, 3)), rand64(), rand64());
      else
        it = register_noise();
      send_item(it);
      counted++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_tag_formats();
    test_abort_open_packet();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0 || seen_valid) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && due_results.size() == 0 && !seen_valid) begin
      $display("graphics_tag_packet_deframer_unit verification clean");
    end else begin
      $display("graphics_tag_packet_deframer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("graphics_tag_packet_deframer_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gtd_pkg.sv
rtl/gtd_front.sv
rtl/gtd_queue.sv
rtl/gtd_back.sv
rtl/graphics_tag_packet_deframer_unit.sv
bench/testbench.sv
